FILE: design/yuvcr_pkg.sv
// yuvcr_pkg: shared types and constants of the yuv chroma resampler
// register indexes, default sizes, flag struct between front and back
// no dependencies
`timescale 1ns / 1ps

package yuvcr_pkg;

   localparam int MAX_WIDTH_DEFAULT   = 4096;
   localparam int MAX_HEIGHT_DEFAULT  = 4096;
   localparam int SAMPLE_BITS_DEFAULT = 8;
   localparam int PERIOD_BITS_DEFAULT = 4;

   localparam int NUM_PLANES   = 3;
   localparam int NUM_PHASES   = 6;
   localparam int DIM_REG_BITS = 13;
   localparam int PER_REG_BITS = 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = DIM_REG_BITS;
   localparam int QUEUE_DEPTH  = 4;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_LINE_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_SRC_LUMA     = 3'd2,
      REG_SRC_CB       = 3'd3,
      REG_SRC_CR       = 3'd4,
      REG_DST_LUMA     = 3'd5,
      REG_DST_CB       = 3'd6,
      REG_DST_CR       = 3'd7
   } csr_index_type;

   localparam logic [DIM_REG_BITS-1:0] LINE_WIDTH_RESET   = 13'd640;
   localparam logic [DIM_REG_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [PER_REG_BITS-1:0] SRC_LUMA_RESET     = 8'h11;
   localparam logic [PER_REG_BITS-1:0] SRC_CHROMA_RESET   = 8'h22;
   localparam logic [PER_REG_BITS-1:0] DST_LUMA_RESET     = 8'h11;
   localparam logic [PER_REG_BITS-1:0] DST_CHROMA_RESET   = 8'h12;

   // classification of one raster position, planes ordered y, u, v
   typedef struct packed {
      logic [NUM_PLANES-1:0] src_hit;
      logic [NUM_PLANES-1:0] dst_hit;
      logic                  line_end;
      logic                  frame_end;
   } pos_flags_type;

   localparam int FLAG_BITS = $bits(pos_flags_type);

endpackage

FILE: design/yuvcr_front.sv
// yuvcr_front: raster position tracking and sample point classification
// depends on yuvcr_pkg
`timescale 1ns / 1ps

module yuvcr_front #(
   parameter int MAX_WIDTH   = yuvcr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT  = yuvcr_pkg::MAX_HEIGHT_DEFAULT,
   parameter int PERIOD_BITS = yuvcr_pkg::PERIOD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic [yuvcr_pkg::DIM_REG_BITS-1:0]     line_width,
   input  logic [yuvcr_pkg::DIM_REG_BITS-1:0]     frame_height,
   input  logic [yuvcr_pkg::NUM_PHASES-1:0][yuvcr_pkg::PER_REG_BITS-1:0] periods,
   output yuvcr_pkg::pos_flags_type               flags
);
   import yuvcr_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int W_BITS = (COL_BITS + 1 > DIM_REG_BITS) ? COL_BITS + 1 : DIM_REG_BITS;
   localparam int H_BITS = (ROW_BITS + 1 > DIM_REG_BITS) ? ROW_BITS + 1 : DIM_REG_BITS;
   localparam int PB = PERIOD_BITS;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [NUM_PHASES-1:0][PB-1:0] hph_ff, hph_in, vph_ff, vph_in;

   logic [W_BITS-1:0] width_raw, width_eff, col_plus;
   logic [H_BITS-1:0] height_raw, height_eff, row_plus;
   logic line_end, frame_end;
   logic [NUM_PHASES-1:0] hit;

   // geometry: zero acts as one, oversize saturates
   always_comb begin
      width_raw  = W_BITS'(line_width);
      height_raw = H_BITS'(frame_height);
      if (width_raw == '0) begin
         width_eff = W_BITS'(1);
      end else if (width_raw > W_BITS'(MAX_WIDTH)) begin
         width_eff = W_BITS'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (height_raw == '0) begin
         height_eff = H_BITS'(1);
      end else if (height_raw > H_BITS'(MAX_HEIGHT)) begin
         height_eff = H_BITS'(MAX_HEIGHT);
      end else begin
         height_eff = height_raw;
      end
      col_plus  = W_BITS'(col_ff) + W_BITS'(1);
      row_plus  = H_BITS'(row_ff) + H_BITS'(1);
      line_end  = col_plus >= width_eff;
      frame_end = line_end && (row_plus >= height_eff);
   end

   // per-phase period decode and next phase
   always_comb begin
      logic [2*PB-1:0] pext;
      logic [PB-1:0]   hper, vper;
      for (int k = 0; k < NUM_PHASES; k++) begin
         pext = (2*PB)'(periods[k]);
         hper = (pext[PB-1:0] == '0) ? PB'(1) : pext[PB-1:0];
         vper = (pext[2*PB-1:PB] == '0) ? PB'(1) : pext[2*PB-1:PB];
         hit[k] = (hph_ff[k] == '0) && (vph_ff[k] == '0);
         if (line_end) begin
            hph_in[k] = '0;
            if (frame_end || ((PB+1)'(vph_ff[k]) + (PB+1)'(1) >= (PB+1)'(vper))) begin
               vph_in[k] = '0;
            end else begin
               vph_in[k] = vph_ff[k] + PB'(1);
            end
         end else begin
            vph_in[k] = vph_ff[k];
            if ((PB+1)'(hph_ff[k]) + (PB+1)'(1) >= (PB+1)'(hper)) begin
               hph_in[k] = '0;
            end else begin
               hph_in[k] = hph_ff[k] + PB'(1);
            end
         end
      end
   end

   always_comb begin
      if (line_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + ROW_BITS'(1);
      end else begin
         col_in = col_ff + COL_BITS'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         hph_ff <= '0;
         vph_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
         hph_ff <= hph_in;
         vph_ff <= vph_in;
      end
   end

   assign flags.src_hit   = hit[NUM_PLANES-1:0];
   assign flags.dst_hit   = hit[NUM_PHASES-1:NUM_PLANES];
   assign flags.line_end  = line_end;
   assign flags.frame_end = frame_end;

endmodule

FILE: design/yuvcr_queue.sv
// yuvcr_queue: short register fifo between front and back
// depends on yuvcr_pkg for the default depth
`timescale 1ns / 1ps

module yuvcr_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = yuvcr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   import yuvcr_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DEPTH-1:0][WIDTH-1:0] slot_ff;
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full      = cnt_ff == CNT_BITS'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + PTR_BITS'(1);
      end
      cnt_in = cnt_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: design/yuvcr_back.sv
// yuvcr_back: sample-and-hold per plane and the registered result stage
// depends on yuvcr_pkg
`timescale 1ns / 1ps

module yuvcr_back #(
   parameter int SAMPLE_BITS = yuvcr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          q_valid,
   input  logic [yuvcr_pkg::NUM_PLANES*SAMPLE_BITS-1:0]  q_samples,
   input  yuvcr_pkg::pos_flags_type                      q_flags,
   output logic                                          q_pop,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [yuvcr_pkg::NUM_PLANES*(SAMPLE_BITS+1)-1:0] out_data,
   output logic                                          out_line_end,
   output logic                                          out_frame_end
);
   import yuvcr_pkg::*;

   localparam int SB = SAMPLE_BITS;

   logic [NUM_PLANES-1:0][SB-1:0] held_ff, held_in;
   logic [NUM_PLANES*(SB+1)-1:0]  data_ff, data_in;
   logic valid_ff, last_ff, frame_ff;

   assign q_pop = q_valid && (!valid_ff || out_ready);

   // latch before emit: a fresh source sample is shown at once
   always_comb begin
      for (int k = 0; k < NUM_PLANES; k++) begin
         held_in[k] = q_flags.src_hit[k] ? q_samples[k*SB +: SB] : held_ff[k];
         data_in[k*(SB+1) +: SB+1] = {q_flags.dst_hit[k], held_in[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            held_ff  <= held_in;
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff  <= data_in;
         last_ff  <= q_flags.line_end;
         frame_ff <= q_flags.frame_end;
      end
   end

   assign out_valid     = valid_ff;
   assign out_data      = data_ff;
   assign out_line_end  = last_ff;
   assign out_frame_end = frame_ff;

endmodule

FILE: design/yuv_chroma_resampler_unit.sv
// yuv_chroma_resampler_unit: top level of the yuv chroma resampler
// holds the control registers, ties front, queue and back together
// depends on yuvcr_pkg, yuvcr_front, yuvcr_queue, yuvcr_back
`timescale 1ns / 1ps

//  channel   dir   handshake             payload
//  req       in    req_tvalid/tready     tdata: luma_in, cb_in, cr_in
//  rsp       out   rsp_tvalid/tready     tdata: y,yv,u,uv,v,vv  tlast: line_end
//                                        tuser: frame_end
//  csr       in    csr_we                csr_addr, csr_wdata
//
//  one item per clock sustained while rsp_tready stays high; rsp_tvalid rises once the
//  result register loads (front classifies and queues in the accept cycle; back pops it)
//  req_tready drops only when the four-entry queue is full
//  reset is synchronous: clears counters, phases and held samples, reloads register defaults
//  a stalled rsp holds its item while the queue keeps absorbing input

module yuv_chroma_resampler_unit #(
   parameter int MAX_WIDTH   = yuvcr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT  = yuvcr_pkg::MAX_HEIGHT_DEFAULT,
   parameter int SAMPLE_BITS = yuvcr_pkg::SAMPLE_BITS_DEFAULT,
   parameter int PERIOD_BITS = yuvcr_pkg::PERIOD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // input items
   input  logic req_tvalid,
   output logic req_tready,
   // luma_in, cb_in, cr_in from the lowest bit up, zero padded to bytes
   input  logic [((yuvcr_pkg::NUM_PLANES*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // result items
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // luma_out, luma_valid, cb_out, cb_valid, cr_out, cr_valid from the lowest bit up
   output logic [((yuvcr_pkg::NUM_PLANES*(SAMPLE_BITS+1)+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast,
   // frame_end
   output logic rsp_tuser,
   // control register writes
   input  logic                                   csr_we,
   input  yuvcr_pkg::csr_index_type               csr_addr,
   input  logic [yuvcr_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import yuvcr_pkg::*;

   localparam int SB       = SAMPLE_BITS;
   localparam int IN_BITS  = NUM_PLANES * SB;
   localparam int OUT_BITS = NUM_PLANES * (SB + 1);
   localparam int RSP_W    = ((OUT_BITS + 7) / 8) * 8;
   localparam int Q_W      = IN_BITS + FLAG_BITS;

   // control registers
   logic [DIM_REG_BITS-1:0] width_ff, height_ff;
   logic [NUM_PHASES-1:0][PER_REG_BITS-1:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= LINE_WIDTH_RESET;
         height_ff    <= FRAME_HEIGHT_RESET;
         period_ff[0] <= SRC_LUMA_RESET;
         period_ff[1] <= SRC_CHROMA_RESET;
         period_ff[2] <= SRC_CHROMA_RESET;
         period_ff[3] <= DST_LUMA_RESET;
         period_ff[4] <= DST_CHROMA_RESET;
         period_ff[5] <= DST_CHROMA_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_LINE_WIDTH:   width_ff     <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff    <= csr_wdata;
            REG_SRC_LUMA:     period_ff[0] <= csr_wdata[PER_REG_BITS-1:0];
            REG_SRC_CB:       period_ff[1] <= csr_wdata[PER_REG_BITS-1:0];
            REG_SRC_CR:       period_ff[2] <= csr_wdata[PER_REG_BITS-1:0];
            REG_DST_LUMA:     period_ff[3] <= csr_wdata[PER_REG_BITS-1:0];
            REG_DST_CB:       period_ff[4] <= csr_wdata[PER_REG_BITS-1:0];
            REG_DST_CR:       period_ff[5] <= csr_wdata[PER_REG_BITS-1:0];
            default:          width_ff     <= width_ff;
         endcase
      end
   end

   // front: position and phase tracking, advances on every accepted item
   pos_flags_type front_flags, q_flags;
   logic q_full, q_not_empty, q_pop, req_accept;
   logic [Q_W-1:0] q_push_data, q_pop_data;

   assign req_tready  = !q_full;
   assign req_accept  = req_tvalid && req_tready;

   yuvcr_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_accept),
      .line_width   (width_ff),
      .frame_height (height_ff),
      .periods      (period_ff),
      .flags        (front_flags)
   );

   // queue entry: samples above the classification flags
   assign q_push_data = {req_tdata[IN_BITS-1:0], front_flags};

   yuvcr_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   assign q_flags = q_pop_data[FLAG_BITS-1:0];

   // back: sample-and-hold and the result register
   logic [OUT_BITS-1:0] back_data;

   yuvcr_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_not_empty),
      .q_samples     (q_pop_data[Q_W-1:FLAG_BITS]),
      .q_flags       (q_flags),
      .q_pop         (q_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (back_data),
      .out_line_end  (rsp_tlast),
      .out_frame_end (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(back_data);

endmodule

FILE: sim/tb.sv
// tb: self-checking bench for yuv_chroma_resampler_unit, one raster position per item
// a sample-and-hold tracker predicts every result item, random bursts and stalls on both sides
// depends on yuvcr_pkg and the resampler rtl
`timescale 1ns / 1ps

import yuvcr_pkg::*;

class chroma_hold_tracker;
   typedef struct packed {
      logic       frame_end;
      logic       line_end;
      logic       cr_valid;
      logic [7:0] cr;
      logic       cb_valid;
      logic [7:0] cb;
      logic       luma_valid;
      logic [7:0] luma;
   } pixel_result_type;

   logic [12:0]   line_width_reg;
   logic [12:0]   frame_height_reg;
   logic [7:0]    period_reg [NUM_PHASES];
   logic [11:0]   column_q;
   logic [11:0]   row_q;
   logic [7:0]    held [NUM_PLANES];
   logic [3:0]    hphase [NUM_PHASES];
   logic [3:0]    vphase [NUM_PHASES];
   pixel_result_type expected_pixels [$];
   int            mismatches;
   int unsigned   results_seen;

   function new();
      line_width_reg   = LINE_WIDTH_RESET;
      frame_height_reg = FRAME_HEIGHT_RESET;
      period_reg[0]    = SRC_LUMA_RESET;
      period_reg[1]    = SRC_CHROMA_RESET;
      period_reg[2]    = SRC_CHROMA_RESET;
      period_reg[3]    = DST_LUMA_RESET;
      period_reg[4]    = DST_CHROMA_RESET;
      period_reg[5]    = DST_CHROMA_RESET;
      column_q = '0;
      row_q    = '0;
      for (int k = 0; k < NUM_PLANES; k++) held[k] = '0;
      for (int k = 0; k < NUM_PHASES; k++) begin
         hphase[k] = '0;
         vphase[k] = '0;
      end
      mismatches   = 0;
      results_seen = 0;
   endfunction

   function void set_reg(csr_index_type idx, logic [12:0] value);
      case (idx)
         REG_LINE_WIDTH: begin
            line_width_reg = value;
         end
         REG_FRAME_HEIGHT: begin
            frame_height_reg = value;
         end
         default: begin
            period_reg[int'(idx) - int'(REG_SRC_LUMA)] = value[7:0];
         end
      endcase
   endfunction

   // zero acts as one, oversized saturates
   function logic [12:0] dim_limit(logic [12:0] value, int bound);
      if (value == '0) return 13'd1;
      if (value > bound) return 13'(bound);
      return value;
   endfunction

   function logic [4:0] period_of(logic [3:0] nibble);
      return (nibble == '0) ? 5'd1 : {1'b0, nibble};
   endfunction

   function logic [3:0] advance(logic [3:0] phase, logic [4:0] period);
      return (({1'b0, phase} + 5'd1) >= period) ? 4'd0 : phase + 4'd1;
   endfunction

   function void report(string what);
      if (mismatches < 100) $display("mismatch at result %0d: %s", results_seen, what);
      mismatches++;
   endfunction

   // one accepted raster position: latch, emit, then step the phases and counters
   function void take_pixel(logic [23:0] pix);
      logic [12:0]   width;
      logic [12:0]   height;
      logic          hit [NUM_PHASES];
      logic          at_line_end;
      logic          at_frame_end;
      logic [4:0]    hper;
      logic [4:0]    vper;
      pixel_result_type r;
      width  = dim_limit(line_width_reg, MAX_WIDTH_DEFAULT);
      height = dim_limit(frame_height_reg, MAX_HEIGHT_DEFAULT);
      for (int k = 0; k < NUM_PHASES; k++) hit[k] = (hphase[k] == '0) && (vphase[k] == '0);
      for (int k = 0; k < NUM_PLANES; k++) if (hit[k]) held[k] = pix[8*k +: 8];
      at_line_end  = ({1'b0, column_q} + 13'd1) >= width;
      at_frame_end = at_line_end && (({1'b0, row_q} + 13'd1) >= height);
      r.luma       = held[0];
      r.luma_valid = hit[NUM_PLANES];
      r.cb         = held[1];
      r.cb_valid   = hit[NUM_PLANES + 1];
      r.cr         = held[2];
      r.cr_valid   = hit[NUM_PLANES + 2];
      r.line_end   = at_line_end;
      r.frame_end  = at_frame_end;
      expected_pixels.push_back(r);
      for (int k = 0; k < NUM_PHASES; k++) begin
         hper = period_of(period_reg[k][3:0]);
         vper = period_of(period_reg[k][7:4]);
         if (at_line_end) begin
            hphase[k] = '0;
            vphase[k] = at_frame_end ? 4'd0 : advance(vphase[k], vper);
         end else begin
            hphase[k] = advance(hphase[k], hper);
         end
      end
      if (at_line_end) begin
         column_q = '0;
         row_q    = at_frame_end ? 12'd0 : row_q + 12'd1;
      end else begin
         column_q = column_q + 12'd1;
      end
   endfunction

   function void compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
   endfunction

   function void check_pixel(logic [31:0] data, logic last, logic user);
      pixel_result_type want;
      if (expected_pixels.size() == 0) begin
         report("result item with nothing expected");
         results_seen++;
         return;
      end
      want = expected_pixels.pop_front();
      compare_field("luma_out", data[7:0], want.luma);
      compare_field("luma_valid", {7'd0, data[8]}, {7'd0, want.luma_valid});
      compare_field("cb_out", data[16:9], want.cb);
      compare_field("cb_valid", {7'd0, data[17]}, {7'd0, want.cb_valid});
      compare_field("cr_out", data[25:18], want.cr);
      compare_field("cr_valid", {7'd0, data[26]}, {7'd0, want.cr_valid});
      compare_field("line_end", {7'd0, last}, {7'd0, want.line_end});
      compare_field("frame_end", {7'd0, user}, {7'd0, want.frame_end});
      results_seen++;
   endfunction
endclass

module tb;
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [23:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic          rsp_tlast;
   logic          rsp_tuser;
   logic          csr_we = 1'b0;
   csr_index_type csr_addr = REG_LINE_WIDTH;
   logic [12:0]   csr_wdata = '0;

   chroma_hold_tracker tracker;

   // register values for the next idle window, indexed like the csr map
   logic [12:0] next_regs [8];
   // sender burst state
   int burst_left  = 0;
   bit steady_feed = 1'b0;
   // receiver stall pattern state
   int stall_tick  = 0;
   int stall_style = 0;

   always #10 clock = ~clock;

   yuv_chroma_resampler_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // receiver: switches between always ready, random stalls
   // and a fixed repeating stall pattern
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 48 == 47) stall_style <= $urandom_range(0, 2);
      case (stall_style)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= (stall_tick % 16) < 9;
         end
      endcase
   end

   // outputs are stable at the falling edge, the item moves at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         tracker.check_pixel(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // one raster position; a new burst may start with a gap
   task automatic send_pixel(input logic [23:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_feed ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      burst_left--;
      tracker.take_pixel(pix);
   endtask

   // stop feeding and let every expected item come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (tracker.expected_pixels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // writes all eight registers back to back, enable stays high throughout
   task automatic set_registers();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= csr_index_type'(i);
         csr_wdata <= next_regs[i];
         @(posedge clock);
         tracker.set_reg(csr_index_type'(i), next_regs[i]);
      end
      csr_we <= 1'b0;
   endtask

   // mostly short lines so frames wrap often, sometimes zero or oversized
   function automatic logic [12:0] pick_dim(int short_max);
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'd1;
         2: return ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'h1FFF;
         3: return 13'($urandom_range(4097, 8191));
         default: return 13'($urandom_range(1, short_max));
      endcase
   endfunction

   // low nibble horizontal, high nibble vertical; upper write bits are don't care
   function automatic logic [12:0] pick_period();
      logic [7:0] p;
      case ($urandom_range(0, 7))
         0: p = 8'h00;
         1: p = 8'hFF;
         2: p = 8'($urandom);
         default: p = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 4))};
      endcase
      return {5'($urandom), p};
   endfunction

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int random_items;
      int n;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset layout: both points on the first position, latched value comes out
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hA5A5A5);
      send_pixel(24'h5A5A5A);
      wait_idle();

      // zero geometry and zero periods: every position ends a frame and is a point
      // counters are mid-line here, so they must wrap on the first step
      next_regs = '{13'd0, 13'd0, 13'h1F00, 13'd0, 13'd0, 13'd0, 13'd0, 13'h0100};
      set_registers();
      for (int i = 0; i < 4; i++) send_pixel(24'($urandom));
      wait_idle();

      // tiny frame, longest periods, one plane at period one
      next_regs = '{13'd3, 13'd2, 13'hFF, 13'hFF, 13'hFF, 13'h00, 13'hFF, 13'h21};
      set_registers();
      for (int i = 0; i < 8; i++) send_pixel(24'($urandom));
      wait_idle();

      // oversized width saturates, height at the maximum, mixed periods
      next_regs = '{13'h1FFF, 13'd4096, 13'h12, 13'h21, 13'h11, 13'h11, 13'h22, 13'h13};
      set_registers();
      for (int i = 0; i < 5; i++) send_pixel(24'($urandom));
      wait_idle();

      // random layouts, each followed by a run of positions
      random_items = 0;
      while (random_items < 600) begin
         next_regs[0] = pick_dim(12);
         next_regs[1] = pick_dim(6);
         for (int i = 2; i < 8; i++) next_regs[i] = pick_period();
         set_registers();
         steady_feed = ($urandom_range(0, 3) == 0);
         n = $urandom_range(30, 90);
         for (int i = 0; i < n; i++) send_pixel(24'($urandom));
         random_items += n;
         wait_idle();
      end

      // keep the clock running for anything unexpected still in flight
      repeat (8) @(posedge clock);
      if (tracker.expected_pixels.size() != 0) tracker.report("expected items never arrived");
      if (tracker.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
